/* hdl/xcfr_pkg.sv */
package xcfr_pkg;

    localparam int unsigned JOB_LEN_W  = 7;
    localparam int unsigned STORE_AW_W = 6;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_ADDR    = 3'd1;
    localparam logic [2:0] ST_LEN     = 3'd2;
    localparam logic [2:0] ST_CSUM    = 3'd3;
    localparam logic [2:0] ST_TAIL    = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;

    localparam logic [2:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] CFG_MODULE_ADDR   = 3'd2;
    localparam logic [2:0] CFG_MAX_LENGTH    = 3'd3;
    localparam logic [2:0] CFG_TAIL_VALUE    = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ADDR,
        PH_LEN,
        PH_DATA,
        PH_CSUM,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } t_bstate;

    // status only for errors; a run carries ST_PAYLOAD and its length
    typedef struct packed {
        logic [2:0]           status;
        logic [JOB_LEN_W-1:0] len;
    } t_job;

    typedef struct packed {
        logic                  en;
        logic [STORE_AW_W-1:0] addr;
        logic [7:0]            data;
    } t_store_wr;

endpackage

/* hdl/xcfr_front.sv */
module xcfr_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_rx_byte,
    output logic               o_enq,
    output xcfr_pkg::t_job     o_job,
    input  logic               i_q_ready,
    input  logic               i_busy,
    output xcfr_pkg::t_store_wr o_wr
);
    import xcfr_pkg::*;

    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]  r_hdr1, r_hdr2, r_addr, r_tail;
    logic [5:0]  r_maxlen;
    logic [15:0] r_tmo;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_taken, n_taken;
    logic [15:0] r_elapsed, n_elapsed;

    logic          acc;
    logic          in_frame;
    logic [15:0]   tick_inc;
    logic          len_bad;
    logic [LW-1:0] taken_inc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !i_q_ready || (r_phase == PH_DATA && i_busy);
    assign acc         = i_valid && !o_stall;
    assign in_frame    = r_phase inside {[PH_ADDR:PH_TAIL]};
    assign tick_inc    = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign len_bad     = (i_rx_byte > {2'b00, r_maxlen}) || (i_rx_byte > 8'(MAX_PAYLOAD));
    assign taken_inc   = r_taken + LW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1   <= 8'h55;
            r_hdr2   <= 8'hAA;
            r_addr   <= 8'h01;
            r_maxlen <= 6'd28;
            r_tail   <= 8'hF0;
            r_tmo    <= 16'd300;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr1   <= i_cfg_data[7:0];
                CFG_HEADER_SECOND: r_hdr2   <= i_cfg_data[7:0];
                CFG_MODULE_ADDR:   r_addr   <= i_cfg_data[7:0];
                CFG_MAX_LENGTH:    r_maxlen <= i_cfg_data[5:0];
                CFG_TAIL_VALUE:    r_tail   <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_tmo    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_len     = r_len;
        n_taken   = r_taken;
        n_elapsed = r_elapsed;
        if (acc) begin
            if (i_opcode == OP_TICK) begin
                if (in_frame) begin
                    n_elapsed = tick_inc;
                    if (tick_inc > r_tmo) n_phase = PH_HUNT1;
                end
            end else begin
                case (r_phase)
                    PH_HUNT1: begin
                        if (i_rx_byte == r_hdr1) n_phase = PH_HUNT2;
                    end
                    PH_HUNT2: begin
                        if (i_rx_byte == r_hdr2) begin
                            n_phase   = PH_ADDR;
                            n_xor     = 8'h00;
                            n_elapsed = 16'd0;
                        end else if (i_rx_byte != r_hdr1) begin
                            n_phase = PH_HUNT1;
                        end
                    end
                    PH_ADDR: begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_phase = (i_rx_byte == r_addr) ? PH_LEN : PH_HUNT1;
                    end
                    PH_LEN: begin
                        n_xor = r_xor ^ i_rx_byte;
                        if (len_bad) begin
                            n_phase = PH_HUNT1;
                        end else begin
                            n_len   = LW'(i_rx_byte);
                            n_taken = '0;
                            n_phase = (i_rx_byte == 8'h00) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_taken = taken_inc;
                        if (taken_inc >= r_len) n_phase = PH_CSUM;
                    end
                    PH_CSUM: begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_phase = PH_TAIL;
                    end
                    default: n_phase = PH_HUNT1;
                endcase
            end
        end
    end

    // queue requests and store writes
    always_comb begin
        o_enq = 1'b0;
        o_job = '0;
        o_wr  = '0;
        if (acc) begin
            if (i_opcode == OP_TICK) begin
                if (in_frame && tick_inc > r_tmo) begin
                    o_enq        = 1'b1;
                    o_job.status = ST_TIMEOUT;
                end
            end else begin
                case (r_phase)
                    PH_ADDR: begin
                        if (i_rx_byte != r_addr) begin
                            o_enq        = 1'b1;
                            o_job.status = ST_ADDR;
                        end
                    end
                    PH_LEN: begin
                        if (len_bad) begin
                            o_enq        = 1'b1;
                            o_job.status = ST_LEN;
                        end
                    end
                    PH_DATA: begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = STORE_AW_W'(r_taken);
                        o_wr.data = i_rx_byte;
                    end
                    PH_TAIL: begin
                        if (r_xor != 8'h00) begin
                            o_enq        = 1'b1;
                            o_job.status = ST_CSUM;
                        end else if (i_rx_byte != r_tail) begin
                            o_enq        = 1'b1;
                            o_job.status = ST_TAIL;
                        end else if (r_len != '0) begin
                            o_enq        = 1'b1;
                            o_job.status = ST_PAYLOAD;
                            o_job.len    = JOB_LEN_W'(r_len);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_xor     <= 8'h00;
            r_len     <= '0;
            r_taken   <= '0;
            r_elapsed <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_xor     <= n_xor;
            r_len     <= n_len;
            r_taken   <= n_taken;
            r_elapsed <= n_elapsed;
        end
    end

    a_enq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_enq |-> i_q_ready)
        else $error("request pushed into full queue");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_taken < r_len)
        else $error("payload count past frame length");

    a_idle_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_opcode == OP_TICK && !in_frame) |=> $stable(r_elapsed))
        else $error("tick counted outside a frame");

endmodule

/* hdl/xcfr_queue.sv */
module xcfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xcfr_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output xcfr_pkg::t_job o_job,
    input  logic           i_pop
);
    import xcfr_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_cnt != 2'd2)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("queue underflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count out of step");

endmodule

/* hdl/xcfr_back.sv */
module xcfr_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xcfr_pkg::t_store_wr i_wr,
    input  logic                i_job_valid,
    input  xcfr_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_active,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [7:0]          o_payload_byte,
    output logic [4:0]          o_payload_index,
    output logic                o_last
);
    import xcfr_pkg::*;

    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic [7:0] r_rd;

    t_bstate       r_state, n_state;
    logic [LW-1:0] r_k, r_len;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [7:0]    r_byte;
    logic [4:0]    r_index;
    logic          r_last;

    logic out_free, is_last, load_err, load_pay;

    assign out_free = !r_out_valid || !i_stall;
    assign is_last  = (r_k + LW'(1)) == r_len;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_k[AW-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid && out_free && i_job.status == ST_PAYLOAD) n_state = B_READ;
            end
            B_READ: n_state = B_SEND;
            B_SEND: begin
                if (out_free) n_state = is_last ? B_IDLE : B_READ;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = 1'b0;
        load_err = 1'b0;
        load_pay = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_pop    = i_job_valid && out_free;
                load_err = o_pop && i_job.status != ST_PAYLOAD;
            end
            B_SEND:  load_pay = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_k   <= '0;
            r_len <= LW'(i_job.len);
        end else if (load_pay) begin
            r_k <= r_k + LW'(1);
        end
        if (load_err) begin
            r_status <= i_job.status;
            r_byte   <= 8'h00;
            r_index  <= 5'd0;
            r_last   <= 1'b1;
        end else if (load_pay) begin
            r_status <= ST_PAYLOAD;
            r_byte   <= r_rd;
            r_index  <= 5'(r_k);
            r_last   <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_err || load_pay) r_out_valid <= 1'b1;
            else if (!i_stall)        r_out_valid <= 1'b0;
        end
    end

    assign o_active        = (r_state != B_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_payload_byte  = r_byte;
    assign o_payload_index = r_index;
    assign o_last          = r_last;

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_SEND |-> r_k < r_len)
        else $error("run index past length");

    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (r_state == B_IDLE && !i_job_valid))
        else $error("store written while a run is pending");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_PAYLOAD) |-> r_last)
        else $error("error item without last mark");

endmodule

/* hdl/xor_checked_frame_receiver_top.sv */
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+------------------------------------------
// input     | in        | i_valid / o_stall       | i_opcode, i_rx_byte
// result    | out       | o_valid / i_stall       | o_status, o_payload_byte, o_payload_index,
//           |           |                         | o_last
// config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Front parser takes one request per cycle while o_stall is low; a 2-entry queue feeds the emitter.
// A good frame's payload is read from the store byte by byte through a read and a send state
// (registered read, then output register); error items go straight to the output register.
// Data-phase requests stall while the queue holds a request or a run is being emitted;
// every request stalls while the queue is full.
// Reset is synchronous active low; the payload store has no reset.
module xor_checked_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_payload_index,
    output logic        o_last
);
    import xcfr_pkg::*;

    logic      enq, q_ready, q_valid, pop, back_active, busy;
    t_job      enq_job, q_job;
    t_store_wr wr;

    assign busy = q_valid || back_active;

    xcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .o_enq       (enq),
        .o_job       (enq_job),
        .i_q_ready   (q_ready),
        .i_busy      (busy),
        .o_wr        (wr)
    );

    xcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_job   (enq_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    xcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_job_valid     (q_valid),
        .i_job           (q_job),
        .o_pop           (pop),
        .o_active        (back_active),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_last          (o_last)
    );

endmodule
